FILE: design/tses_pkg.sv
// types and constants shared by the homing sequencer modules
package tses_pkg;

    // sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_VSEARCH = 4'd1,
        PH_HSEARCH = 4'd2,
        PH_BACKV   = 4'd3,
        PH_BACKH   = 4'd4,
        PH_SETTLE  = 4'd5,
        PH_TOUCHV  = 4'd6,
        PH_TOUCHH  = 4'd7,
        PH_RELEASE = 4'd8
    } t_phase;

    // status codes
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_RUNNING  = 3'd1;
    localparam logic [2:0] ST_HOMED    = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_SKIPPED  = 3'd4;

    // input word kinds
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_START = 1'b1;

    // configuration register indexes
    localparam logic [2:0] CFG_FAST_PERIOD = 3'd0;
    localparam logic [2:0] CFG_SLOW_PERIOD = 3'd1;
    localparam logic [2:0] CFG_VERT_LIMIT  = 3'd2;
    localparam logic [2:0] CFG_HORZ_LIMIT  = 3'd3;
    localparam logic [2:0] CFG_BACKOFF     = 3'd4;
    localparam logic [2:0] CFG_TOUCH_LIMIT = 3'd5;
    localparam logic [2:0] CFG_SETTLE      = 3'd6;

    // configuration reset values
    localparam logic [15:0] RST_FAST_PERIOD = 16'd400;
    localparam logic [15:0] RST_SLOW_PERIOD = 16'd1000;
    localparam logic [15:0] RST_VERT_LIMIT  = 16'd1500;
    localparam logic [15:0] RST_HORZ_LIMIT  = 16'd1200;
    localparam logic [15:0] RST_BACKOFF     = 16'd30;
    localparam logic [15:0] RST_TOUCH_LIMIT = 16'd50;
    localparam logic [19:0] RST_SETTLE      = 20'd10000;

    // direction patterns
    localparam logic [5:0] DIR_IDLE    = 6'h00;
    localparam logic [5:0] DIR_HOME    = 6'h1F;
    localparam logic [5:0] DIR_BACKOFF = 6'h20;
    localparam logic [5:0] DIR_RELEASE = 6'h2F;

    localparam logic [5:0] ALL_CLOSED = 6'h3F;

    typedef struct packed {
        logic [15:0] fast_period;
        logic [15:0] slow_period;
        logic [15:0] vert_limit;
        logic [15:0] horz_limit;
        logic [15:0] backoff;
        logic [15:0] touch_limit;
        logic [19:0] settle;
    } t_cfg;

    typedef struct packed {
        t_phase      phase;
        logic [2:0]  slot_index;
        logic        vertical_found;
        logic        horizontal_found;
        logic        z_left_done;
        logic        z_right_done;
        logic [3:0]  vertical_move_mask;
        logic [2:0]  last_status;
    } t_ctrl;

    typedef struct packed {
        logic [2:0] status;
        logic       horizontal_enable_n;
        logic       vertical_enable_n;
        logic [5:0] dir_lines;
        logic [5:0] step_lines;
    } t_result;

endpackage

FILE: design/tses_next.sv
// next-state and result logic for one input word of the homing sequencer
module tses_next
    import tses_pkg::*;
#(
    parameter int COUNT_WIDTH = 16,
    parameter int TIMER_WIDTH = 20
) (
    input  logic                   i_kind,
    input  logic [5:0]             i_endstops,
    input  t_ctrl                  i_ctrl,
    input  logic [COUNT_WIDTH-1:0] i_step_count,
    input  logic [TIMER_WIDTH-1:0] i_slot_timer,
    input  t_cfg                   i_cfg,
    output t_ctrl                  o_ctrl,
    output logic [COUNT_WIDTH-1:0] o_step_count,
    output logic [TIMER_WIDTH-1:0] o_slot_timer,
    output t_result                o_result
);

    localparam int CMPW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam int PW   = (TIMER_WIDTH > 20) ? TIMER_WIDTH : 20;
    localparam logic [CMPW-1:0] CNT_TOP = CMPW'((64'd1 << COUNT_WIDTH) - 64'd1);
    localparam logic [PW-1:0]   TMR_TOP = PW'((64'd1 << TIMER_WIDTH) - 64'd1);
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
    // one decision per phase at most, plus the final step
    localparam int CHAIN = 10;

    function automatic logic reach_cur(input logic [COUNT_WIDTH-1:0] cnt,
                                       input logic [15:0] lim);
        logic [CMPW-1:0] l;
        l = CMPW'(lim);
        if (l > CNT_TOP) begin
            l = CNT_TOP;
        end
        return CMPW'(cnt) >= l;
    endfunction

    function automatic logic [TIMER_WIDTH-1:0] cap_tmr(input logic [PW-1:0] v);
        logic [PW-1:0] c;
        c = (v > TMR_TOP) ? TMR_TOP : v;
        return c[TIMER_WIDTH-1:0];
    endfunction

    function automatic logic [5:0] pattern(input t_phase ph, input logic [2:0] s,
                                           input logic [3:0] mask,
                                           input logic zl, input logic zr);
        logic [5:0] p;
        p = 6'h00;
        if (s != 3'd0) begin
            case (ph)
                PH_VSEARCH, PH_BACKV: begin
                    case (s)
                        3'd1:    p = 6'h01;
                        3'd2:    p = 6'h02;
                        3'd3:    p = 6'h04;
                        3'd4:    p = 6'h08;
                        default: p = 6'h00;
                    endcase
                end
                PH_HSEARCH, PH_BACKH: begin
                    case (s)
                        3'd1:    p = 6'h10;
                        3'd2:    p = 6'h20;
                        default: p = 6'h00;
                    endcase
                end
                PH_TOUCHV:  p = {2'b00, mask};
                PH_TOUCHH:  p = {~zl, ~zr, 4'b0000};
                PH_RELEASE: p = 6'h30;
                default:    p = 6'h00;
            endcase
        end
        return p;
    endfunction

    // per-word constants and compares against the current counters
    logic [TIMER_WIDTH-1:0] fast_cap, slow_cap, settle_cap;
    logic vr, hr, br, tr, vz, hz, bz, tz, s_cur, s_zero, cur_nz;

    always_comb begin
        fast_cap   = cap_tmr(PW'((i_cfg.fast_period == 16'd0) ? 16'd1 : i_cfg.fast_period));
        slow_cap   = cap_tmr(PW'((i_cfg.slow_period == 16'd0) ? 16'd1 : i_cfg.slow_period));
        settle_cap = cap_tmr(PW'(i_cfg.settle));
        vr = reach_cur(i_step_count, i_cfg.vert_limit);
        hr = reach_cur(i_step_count, i_cfg.horz_limit);
        br = reach_cur(i_step_count, i_cfg.backoff);
        tr = reach_cur(i_step_count, i_cfg.touch_limit);
        vz = (i_cfg.vert_limit == 16'd0);
        hz = (i_cfg.horz_limit == 16'd0);
        bz = (i_cfg.backoff == 16'd0);
        tz = (i_cfg.touch_limit == 16'd0);
        s_cur  = (i_slot_timer >= settle_cap);
        s_zero = (i_cfg.settle == 20'd0);
        cur_nz = (i_step_count != '0);
    end

    t_phase                 ph, nxt;
    logic [2:0]             slot, slots;
    logic                   vf, hf, zl, zr;
    logic [3:0]             mask;
    logic [2:0]             last;
    logic [TIMER_WIDTH-1:0] tmr, t1, per;
    logic [COUNT_WIDTH-1:0] cnt;
    logic                   fresh, busy, chg, fin, act_settle, act_pulse;
    logic [2:0]             fin_st;
    logic [5:0]             step;

    always_comb begin
        ph    = i_ctrl.phase;
        slot  = i_ctrl.slot_index;
        vf    = i_ctrl.vertical_found;
        hf    = i_ctrl.horizontal_found;
        zl    = i_ctrl.z_left_done;
        zr    = i_ctrl.z_right_done;
        mask  = i_ctrl.vertical_move_mask;
        last  = i_ctrl.last_status;
        tmr   = i_slot_timer;
        cnt   = i_step_count;
        fresh = 1'b0;
        busy  = 1'b1;
        chg   = 1'b0;
        fin   = 1'b0;
        fin_st = ST_IDLE;
        nxt   = PH_IDLE;
        act_settle = 1'b0;
        act_pulse  = 1'b0;
        step  = 6'h00;
        t1    = '0;
        per   = fast_cap;
        slots = 3'd2;

        if (i_kind == KIND_START) begin
            if (ph == PH_IDLE) begin
                if (i_endstops == ALL_CLOSED) begin
                    last = ST_SKIPPED;
                end else begin
                    vf   = |i_endstops[3:2];
                    hf   = 1'b0;
                    mask = 4'h0;
                    last = ST_RUNNING;
                    ph   = PH_VSEARCH;
                    slot = 3'd0;
                    tmr  = '0;
                    cnt  = '0;
                end
            end
            step = pattern(ph, slot, mask, zl, zr);
        end else begin
            // chain of start-of-step decisions, at most one per phase
            for (int i = 0; i < CHAIN; i++) begin
                if (busy) begin
                    chg = 1'b0;
                    fin = 1'b0;
                    if (ph == PH_IDLE) begin
                        busy = 1'b0;
                    end else if (ph == PH_SETTLE) begin
                        if (fresh ? s_zero : s_cur) begin
                            chg = 1'b1;
                            nxt = PH_TOUCHV;
                        end else begin
                            act_settle = 1'b1;
                            busy = 1'b0;
                        end
                    end else begin
                        if (slot == 3'd0 && tmr == '0) begin
                            case (ph)
                                PH_VSEARCH: begin
                                    if (vf || (fresh ? vz : vr)) begin
                                        chg = 1'b1;
                                    end else if (i_endstops[3:0] != 4'h0) begin
                                        vf  = 1'b1;
                                        chg = 1'b1;
                                    end
                                    nxt = PH_HSEARCH;
                                end
                                PH_HSEARCH: begin
                                    if (!fresh && cur_nz && i_endstops[5:4] != 2'b00) begin
                                        hf = 1'b1;
                                    end
                                    if (hf || (fresh ? hz : hr)) begin
                                        if (vf && hf) begin
                                            chg = 1'b1;
                                            nxt = PH_BACKV;
                                        end else begin
                                            fin    = 1'b1;
                                            fin_st = ST_NOTFOUND;
                                        end
                                    end
                                end
                                PH_BACKV: begin
                                    chg = fresh ? bz : br;
                                    nxt = PH_BACKH;
                                end
                                PH_BACKH: begin
                                    chg = fresh ? bz : br;
                                    nxt = PH_SETTLE;
                                end
                                PH_TOUCHV: begin
                                    if ((fresh ? tz : tr) || i_endstops[3:0] == 4'hF) begin
                                        chg = 1'b1;
                                    end else begin
                                        mask = ~i_endstops[3:0];
                                    end
                                    nxt = PH_TOUCHH;
                                end
                                PH_TOUCHH: begin
                                    if ((zl && zr) || (fresh ? tz : tr)) begin
                                        chg = 1'b1;
                                    end else begin
                                        if (i_endstops[4]) zl = 1'b1;
                                        if (i_endstops[5]) zr = 1'b1;
                                    end
                                    nxt = PH_RELEASE;
                                end
                                PH_RELEASE: begin
                                    if (!fresh && cur_nz) begin
                                        fin    = 1'b1;
                                        fin_st = ST_HOMED;
                                    end
                                end
                                default: begin
                                end
                            endcase
                        end
                        if (!chg && !fin) begin
                            act_pulse = 1'b1;
                            busy = 1'b0;
                        end
                    end
                    if (fin) begin
                        ph   = PH_IDLE;
                        slot = 3'd0;
                        tmr  = '0;
                        last = fin_st;
                    end else if (chg) begin
                        ph    = nxt;
                        slot  = 3'd0;
                        tmr   = '0;
                        cnt   = '0;
                        fresh = 1'b1;
                        if (nxt == PH_TOUCHH) begin
                            zl = 1'b0;
                            zr = 1'b0;
                        end
                    end
                end
            end

            // one tick spent in the phase the chain settled on
            if (act_settle) begin
                tmr = tmr + 1'b1;
            end else if (act_pulse) begin
                step = pattern(ph, slot, mask, zl, zr);
                per  = (ph >= PH_TOUCHV) ? slow_cap : fast_cap;
                case (ph)
                    PH_VSEARCH, PH_BACKV: slots = 3'd5;
                    PH_HSEARCH, PH_BACKH: slots = 3'd3;
                    default:              slots = 3'd2;
                endcase
                t1 = tmr + 1'b1;
                if (t1 >= per) begin
                    tmr = '0;
                    if (slot + 3'd1 >= slots) begin
                        slot = 3'd0;
                        if (cnt != CNT_MAX) begin
                            cnt = cnt + 1'b1;
                        end
                    end else begin
                        slot = slot + 3'd1;
                    end
                end else begin
                    tmr = t1;
                end
            end
        end
    end

    always_comb begin
        o_ctrl.phase              = ph;
        o_ctrl.slot_index         = slot;
        o_ctrl.vertical_found     = vf;
        o_ctrl.horizontal_found   = hf;
        o_ctrl.z_left_done        = zl;
        o_ctrl.z_right_done       = zr;
        o_ctrl.vertical_move_mask = mask;
        o_ctrl.last_status        = last;
        o_step_count = cnt;
        o_slot_timer = tmr;

        o_result.step_lines = step;
        case (ph)
            PH_IDLE:            o_result.dir_lines = DIR_IDLE;
            PH_BACKV, PH_BACKH: o_result.dir_lines = DIR_BACKOFF;
            PH_RELEASE:         o_result.dir_lines = DIR_RELEASE;
            default:            o_result.dir_lines = DIR_HOME;
        endcase
        o_result.vertical_enable_n   = (ph == PH_IDLE);
        o_result.horizontal_enable_n = (ph == PH_IDLE);
        o_result.status              = (ph == PH_IDLE) ? last : ST_RUNNING;
    end

endmodule

FILE: design/two_stage_endstop_homing_sequencer_core.sv
// top level of the two-stage end-switch homing sequencer
// Homes four vertical and two horizontal steppers against six end switches. Each input
// word is either a one-microsecond tick carrying the switch levels (tuser 0) or a start
// command (tuser 1), and each input word yields exactly one output word with the step and
// direction pins, the two active-low driver enables and the status. One word is taken
// every clock cycle while the result register is free or being emptied; each word passes
// from the input register through the combinational next-state logic into the result
// register, which drives the output. Configuration writes take effect at once
// and are meant for while the sequencer is idle with no word in flight.
module two_stage_endstop_homing_sequencer_core
    import tses_pkg::*;
#(
    parameter int COUNT_WIDTH = 16,
    parameter int TIMER_WIDTH = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [19:0] i_cfg_wdata,
    // input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [5:0] endstops, [7:6] zero
    input  logic [0:0]  s_axis_tuser,  // [0] kind
    // output words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // [5:0] step_lines, [11:6] dir_lines,
                                       // [12] vertical_enable_n, [13] horizontal_enable_n,
                                       // [16:14] status, [23:17] zero
);

    // configuration registers
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fast_period <= RST_FAST_PERIOD;
            r_cfg.slow_period <= RST_SLOW_PERIOD;
            r_cfg.vert_limit  <= RST_VERT_LIMIT;
            r_cfg.horz_limit  <= RST_HORZ_LIMIT;
            r_cfg.backoff     <= RST_BACKOFF;
            r_cfg.touch_limit <= RST_TOUCH_LIMIT;
            r_cfg.settle      <= RST_SETTLE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FAST_PERIOD: r_cfg.fast_period <= i_cfg_wdata[15:0];
                CFG_SLOW_PERIOD: r_cfg.slow_period <= i_cfg_wdata[15:0];
                CFG_VERT_LIMIT:  r_cfg.vert_limit  <= i_cfg_wdata[15:0];
                CFG_HORZ_LIMIT:  r_cfg.horz_limit  <= i_cfg_wdata[15:0];
                CFG_BACKOFF:     r_cfg.backoff     <= i_cfg_wdata[15:0];
                CFG_TOUCH_LIMIT: r_cfg.touch_limit <= i_cfg_wdata[15:0];
                CFG_SETTLE:      r_cfg.settle      <= i_cfg_wdata;
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    // input register
    logic       r_in_valid;
    logic       r_in_kind;
    logic [5:0] r_in_sw;
    // result register
    logic       r_out_valid;
    t_result    r_out;
    // sequencer state
    t_ctrl                  r_ctrl;
    logic [COUNT_WIDTH-1:0] r_step_count;
    logic [TIMER_WIDTH-1:0] r_slot_timer;

    t_ctrl                  n_ctrl;
    logic [COUNT_WIDTH-1:0] n_step_count;
    logic [TIMER_WIDTH-1:0] n_slot_timer;
    t_result                n_out;

    logic advance;

    // a held word moves into the result register whenever that register is free or
    // being emptied this cycle, so the input side keeps flowing while the sink is ready
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_kind <= s_axis_tuser[0];
            r_in_sw   <= s_axis_tdata[5:0];
        end
    end

    tses_next #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_next (
        .i_kind       (r_in_kind),
        .i_endstops   (r_in_sw),
        .i_ctrl       (r_ctrl),
        .i_step_count (r_step_count),
        .i_slot_timer (r_slot_timer),
        .i_cfg        (r_cfg),
        .o_ctrl       (n_ctrl),
        .o_step_count (n_step_count),
        .o_slot_timer (n_slot_timer),
        .o_result     (n_out)
    );

    // state advances exactly once per word, as it is handed to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl.phase              <= PH_IDLE;
            r_ctrl.slot_index         <= 3'd0;
            r_ctrl.vertical_found     <= 1'b0;
            r_ctrl.horizontal_found   <= 1'b0;
            r_ctrl.z_left_done        <= 1'b0;
            r_ctrl.z_right_done       <= 1'b0;
            r_ctrl.vertical_move_mask <= 4'h0;
            r_ctrl.last_status        <= ST_IDLE;
            r_step_count              <= '0;
            r_slot_timer              <= '0;
            r_out_valid               <= 1'b0;
        end else begin
            if (advance) begin
                r_ctrl       <= n_ctrl;
                r_step_count <= n_step_count;
                r_slot_timer <= n_slot_timer;
                r_out_valid  <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0000000, r_out.status, r_out.horizontal_enable_n,
                            r_out.vertical_enable_n, r_out.dir_lines, r_out.step_lines};

endmodule
